@@ sv/rbfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rbfe_pkg
// Shared types, constants and channel math for the RGB bulb fade engine.
// ----------------------------------------------------------------------------
package rbfe_pkg;

  localparam int unsigned MAX_BULBS  = 8;
  localparam int unsigned IdxW       = $clog2(MAX_BULBS);
  localparam int unsigned CntW       = 3;
  localparam int unsigned MaxTick    = (MAX_BULBS < 6) ? MAX_BULBS : 6;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned ApbAddrW   = 2;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [7:0] SnapLimit = 8'd12;

  typedef enum logic [2:0] {
    OP_SET_TGT_ONE = 3'd0,
    OP_SET_CUR_ONE = 3'd1,
    OP_SET_TGT_ALL = 3'd2,
    OP_SET_CUR_ALL = 3'd3,
    OP_TICK        = 3'd4,
    OP_READ        = 3'd5
  } op_e;

  localparam logic [ApbAddrW-1:0] RegBulbCount = '0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t CurReset = '{red: 8'd0, green: 8'd0, blue: 8'd0};
  localparam rgb_t TgtReset = '{red: 8'd128, green: 8'd0, blue: 8'd77};

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] bulb;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] frame_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bulb_index;
    logic [7:0] cur_red;
    logic [7:0] cur_green;
    logic [7:0] cur_blue;
    logic [7:0] tgt_red;
    logic [7:0] tgt_green;
    logic [7:0] tgt_blue;
    logic       last;
  } out_item_t;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    op_e             op;
    logic [2:0]      bulb;
    logic            ok;
    rgb_t            rgb;
    logic [7:0]      frame_time;
    logic [CntW-1:0] count;
  } cmd_t;

  // floor(2(i+2) / 3n) with i < n is never above 1, so it reduces to a compare
  function automatic logic tick_factor(logic [IdxW-1:0] i, logic [CntW-1:0] n);
    logic [7:0] a;
    logic [7:0] b;
    a = 8'(i) + 8'd2;
    b = 8'(n) * 8'd3;
    return ({a[6:0], 1'b0} >= b);
  endfunction

  function automatic logic [7:0] step_channel(logic [7:0] cur, logic [7:0] tgt,
                                             logic [7:0] delta);
    logic [7:0] span;
    logic [8:0] up;
    logic [7:0] res;
    span = (cur > tgt) ? (cur - tgt) : (tgt - cur);
    up   = {1'b0, cur} + {1'b0, delta};
    if (span <= SnapLimit) begin
      res = tgt;
    end else if (tgt > cur) begin
      res = up[8] ? 8'hFF : up[7:0];
    end else begin
      res = (delta > cur) ? 8'h00 : (cur - delta);
    end
    return res;
  endfunction

endpackage

@@ sv/rbfe_front.sv @@
// ----------------------------------------------------------------------------
// rbfe_front
// Input side: takes beats, decodes the op, holds the bulb count register and
// pushes classified commands into the command queue.
// ----------------------------------------------------------------------------
module rbfe_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rbfe_pkg::in_item_t             in_data_i,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbfe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rbfe_pkg::ApbDataW-1:0]  pwdata,
  output logic [rbfe_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  input  logic                           full_i,
  output logic                           push_o,
  output rbfe_pkg::cmd_t                 cmd_o
);

  logic [rbfe_pkg::CntW-1:0] bulb_count_q, bulb_count_d;
  logic                      known;
  logic [rbfe_pkg::CntW-1:0] count_eff;

  assign pready = 1'b1;

  always_comb begin
    bulb_count_d = bulb_count_q;
    if (psel && penable && pwrite && (paddr == rbfe_pkg::RegBulbCount)) begin
      bulb_count_d = pwdata[rbfe_pkg::CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bulb_count_q <= rbfe_pkg::CntW'(1);
    end else begin
      bulb_count_q <= bulb_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == rbfe_pkg::RegBulbCount) begin
      prdata = rbfe_pkg::ApbDataW'(bulb_count_q);
    end
  end

  // Clamp the walk length to 1..MaxTick
  always_comb begin
    priority if (bulb_count_q == '0) begin
      count_eff = rbfe_pkg::CntW'(1);
    end else if (32'(bulb_count_q) > rbfe_pkg::MaxTick) begin
      count_eff = rbfe_pkg::CntW'(rbfe_pkg::MaxTick);
    end else begin
      count_eff = bulb_count_q;
    end
  end

  always_comb begin
    unique case (in_data_i.op)
      rbfe_pkg::OP_SET_TGT_ONE, rbfe_pkg::OP_SET_CUR_ONE,
      rbfe_pkg::OP_SET_TGT_ALL, rbfe_pkg::OP_SET_CUR_ALL,
      rbfe_pkg::OP_TICK,        rbfe_pkg::OP_READ: known = 1'b1;
      default:                                    known = 1'b0;
    endcase
  end

  assign in_ready_o = !full_i;
  // Unknown ops are taken and dropped
  assign push_o     = in_valid_i && !full_i && known;

  always_comb begin
    cmd_o.op         = rbfe_pkg::op_e'(in_data_i.op);
    cmd_o.bulb       = in_data_i.bulb;
    cmd_o.ok         = (32'(in_data_i.bulb) < rbfe_pkg::MAX_BULBS);
    cmd_o.rgb.red    = in_data_i.red;
    cmd_o.rgb.green  = in_data_i.green;
    cmd_o.rgb.blue   = in_data_i.blue;
    cmd_o.frame_time = in_data_i.frame_time;
    cmd_o.count      = count_eff;
  end

endmodule

@@ sv/rbfe_queue.sv @@
// ----------------------------------------------------------------------------
// rbfe_queue
// Short command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module rbfe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbfe_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rbfe_pkg::cmd_t data_o
);

  rbfe_pkg::cmd_t                mem_q [rbfe_pkg::QueueDepth];
  logic [rbfe_pkg::QPtrW-1:0]    wptr_q, wptr_d;
  logic [rbfe_pkg::QPtrW-1:0]    rptr_q, rptr_d;
  logic [rbfe_pkg::QPtrW:0]      cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = (32'(cnt_q) == rbfe_pkg::QueueDepth);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Depth is a power of two, so pointers wrap on their own
  always_comb begin
    wptr_d = do_push ? wptr_q + rbfe_pkg::QPtrW'(1) : wptr_q;
    rptr_d = do_pop  ? rptr_q + rbfe_pkg::QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (rbfe_pkg::QPtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (rbfe_pkg::QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/rbfe_back.sv @@
// ----------------------------------------------------------------------------
// rbfe_back
// Execution side: holds the color stores, carries out one command step per
// cycle while the output register is free (one bulb per cycle on a tick) and drives the output register.
// ----------------------------------------------------------------------------
module rbfe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  rbfe_pkg::cmd_t       cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rbfe_pkg::out_item_t  out_data_o
);

  rbfe_pkg::rgb_t              cur_q [rbfe_pkg::MAX_BULBS];
  rbfe_pkg::rgb_t              tgt_q [rbfe_pkg::MAX_BULBS];
  logic [rbfe_pkg::IdxW-1:0]   idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  rbfe_pkg::out_item_t         out_q;

  logic                        slot_free, fire, emit, tick_last;
  logic [rbfe_pkg::IdxW-1:0]   addr;
  rbfe_pkg::rgb_t              cur_rd, tgt_rd, stepped, res_cur, res_tgt;
  logic [7:0]                  delta;
  logic                        wr_cur_one, wr_tgt_one, wr_cur_all, wr_tgt_all;
  rbfe_pkg::rgb_t              wr_data;
  logic [2:0]                  res_idx;
  logic                        res_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = cmd_valid_i && slot_free;

  assign addr   = (cmd_i.op == rbfe_pkg::OP_TICK) ? idx_q : rbfe_pkg::IdxW'(cmd_i.bulb);
  assign cur_rd = cur_q[addr];
  assign tgt_rd = tgt_q[addr];

  assign delta     = rbfe_pkg::tick_factor(idx_q, cmd_i.count) ? cmd_i.frame_time : 8'd0;
  assign tick_last = ((32'(idx_q) + 32'd1) == 32'(cmd_i.count));

  always_comb begin
    stepped = cur_rd;
    if (cur_rd != tgt_rd) begin
      stepped.red   = rbfe_pkg::step_channel(cur_rd.red,   tgt_rd.red,   delta);
      stepped.green = rbfe_pkg::step_channel(cur_rd.green, tgt_rd.green, delta);
      stepped.blue  = rbfe_pkg::step_channel(cur_rd.blue,  tgt_rd.blue,  delta);
    end
  end

  always_comb begin
    emit       = 1'b0;
    pop_o      = 1'b0;
    idx_d      = idx_q;
    wr_cur_one = 1'b0;
    wr_tgt_one = 1'b0;
    wr_cur_all = 1'b0;
    wr_tgt_all = 1'b0;
    wr_data    = cmd_i.rgb;
    res_cur    = cur_rd;
    res_tgt    = tgt_rd;
    res_idx    = cmd_i.bulb;
    res_last   = 1'b1;
    unique case (cmd_i.op)
      rbfe_pkg::OP_SET_TGT_ONE: begin
        emit       = 1'b1;
        pop_o      = fire;
        wr_tgt_one = fire && cmd_i.ok;
        res_tgt    = cmd_i.rgb;
      end
      rbfe_pkg::OP_SET_CUR_ONE: begin
        emit       = 1'b1;
        pop_o      = fire;
        wr_cur_one = fire && cmd_i.ok;
        res_cur    = cmd_i.rgb;
      end
      rbfe_pkg::OP_SET_TGT_ALL: begin
        pop_o      = fire;
        wr_tgt_all = fire;
      end
      rbfe_pkg::OP_SET_CUR_ALL: begin
        pop_o      = fire;
        wr_cur_all = fire;
      end
      rbfe_pkg::OP_TICK: begin
        // Advance one bulb per beat, drop the command after the last one
        emit       = 1'b1;
        wr_cur_one = fire;
        wr_data    = stepped;
        res_cur    = stepped;
        res_idx    = 3'(idx_q);
        res_last   = tick_last;
        if (fire) begin
          pop_o = tick_last;
          idx_d = tick_last ? '0 : idx_q + rbfe_pkg::IdxW'(1);
        end
      end
      rbfe_pkg::OP_READ: begin
        emit  = 1'b1;
        pop_o = fire;
      end
      default: begin
        pop_o = fire;
      end
    endcase
    if (cmd_i.op != rbfe_pkg::OP_TICK && !cmd_i.ok) begin
      res_cur = rbfe_pkg::CurReset;
      res_tgt = rbfe_pkg::CurReset;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < rbfe_pkg::MAX_BULBS; i++) begin
        cur_q[i] <= rbfe_pkg::CurReset;
        tgt_q[i] <= rbfe_pkg::TgtReset;
      end
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < rbfe_pkg::MAX_BULBS; i++) begin
        if (wr_cur_all || (wr_cur_one && (addr == rbfe_pkg::IdxW'(i)))) begin
          cur_q[i] <= wr_data;
        end
        if (wr_tgt_all || (wr_tgt_one && (addr == rbfe_pkg::IdxW'(i)))) begin
          tgt_q[i] <= wr_data;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q.bulb_index <= res_idx;
      out_q.cur_red    <= res_cur.red;
      out_q.cur_green  <= res_cur.green;
      out_q.cur_blue   <= res_cur.blue;
      out_q.tgt_red    <= res_tgt.red;
      out_q.tgt_green  <= res_tgt.green;
      out_q.tgt_blue   <= res_tgt.blue;
      out_q.last       <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/rgb_bulb_fade_engine.sv @@
// ----------------------------------------------------------------------------
// rgb_bulb_fade_engine
// Per-bulb current/target RGB store with frame-tick fading toward target.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_ready_o  in_item_t  (op, bulb, color, frame_time)
//  out       source     out_valid_o/out_ready_i out_item_t (bulb state, last)
//  config    APB slave  psel/penable/pready    bulb_count at address 0
//
//  A tick walks bulb_count bulbs in the back end (bulb_count clamped to 1..6),
//  one bulb per cycle through the shared channel update while the output is
//  not stalled; every other op is a single command step.
//  Results leave through one output register; a stalled output holds the back end.
//  A two-entry command queue keeps the input side taking beats while the back end works.
//  Reset is asynchronous, active low; color stores reset in place, no clearing pass.
// ----------------------------------------------------------------------------
module rgb_bulb_fade_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rbfe_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rbfe_pkg::out_item_t            out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbfe_pkg::ApbAddrW-1:0]  paddr,
  input  logic [rbfe_pkg::ApbDataW-1:0]  pwdata,
  output logic [rbfe_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  logic           q_full, q_push, q_pop, q_valid;
  rbfe_pkg::cmd_t q_in, q_out;

  rbfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .full_i     (q_full),
    .push_o     (q_push),
    .cmd_o      (q_in)
  );

  rbfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_out)
  );

  rbfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/rbfe_checker.sv @@
// ----------------------------------------------------------------------------
// rbfe_checker
// Port-level checks for the RGB bulb fade engine, bound to the top level.
// ----------------------------------------------------------------------------
module rbfe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input rbfe_pkg::out_item_t            out_data_o,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [rbfe_pkg::ApbAddrW-1:0]  paddr,
  input logic [rbfe_pkg::ApbDataW-1:0]  pwdata,
  input logic [rbfe_pkg::ApbDataW-1:0]  prdata,
  input logic                           pready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready == 1'b1)
    else $error("pready dropped");

  // The count register reads back what was just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr == rbfe_pkg::RegBulbCount) |=>
      (paddr != rbfe_pkg::RegBulbCount) ||
      (prdata[rbfe_pkg::CntW-1:0] == $past(pwdata[rbfe_pkg::CntW-1:0])))
    else $error("bulb count readback mismatch");

  // Only a tick gives non-final beats, and those stop short of bulb five
  a_nonlast_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.last == 1'b0) |-> out_data_o.bulb_index <= 3'd4)
    else $error("non-final beat with out-of-walk bulb index");

endmodule

bind rgb_bulb_fade_engine rbfe_checker u_rbfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .pready      (pready)
);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_bulb_fade_engine. A behavioral copy of the
// color stores predicts every result beat of the single-bulb writes, reads
// and frame ticks. Results are compared in order against that prediction
// while the input side sends in bursts and the output side stalls at random.
// Bulb count is changed over APB between phases, with readback.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TailCycles = 24;
  localparam int MaxReports = 10;

  // ops that the block has no meaning for
  localparam logic [2:0] OpUnusedA = 3'd6;
  localparam logic [2:0] OpUnusedB = 3'd7;

  // address that holds no register
  localparam logic [rbfe_pkg::ApbAddrW-1:0] RegBeyond = '1;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  rbfe_pkg::in_item_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  rbfe_pkg::out_item_t           out_data_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [rbfe_pkg::ApbAddrW-1:0] paddr       = '0;
  logic [rbfe_pkg::ApbDataW-1:0] pwdata      = '0;
  logic [rbfe_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  rgb_bulb_fade_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the bulb stores and the count register
  rbfe_pkg::rgb_t            cur_mdl [rbfe_pkg::MAX_BULBS];
  rbfe_pkg::rgb_t            tgt_mdl [rbfe_pkg::MAX_BULBS];
  logic [rbfe_pkg::CntW-1:0] count_reg;

  rbfe_pkg::out_item_t pending_q [$];
  int                  mismatch_cnt = 0;
  int                  burst_left   = 1;
  int                  gap_max      = 2;
  int                  max_stall    = 3;
  int                  stall_left   = 0;

  function automatic string show(rbfe_pkg::out_item_t r);
    return $sformatf("bulb %0d cur %0d/%0d/%0d tgt %0d/%0d/%0d last %0b", r.bulb_index,
                     r.cur_red, r.cur_green, r.cur_blue, r.tgt_red, r.tgt_green,
                     r.tgt_blue, r.last);
  endfunction

  task automatic note_failure(string msg);
    if (mismatch_cnt < MaxReports) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  function automatic logic [7:0] fade_channel(logic [7:0] cur, logic [7:0] tgt, int delta);
    int c;
    int t;
    int v;
    c = cur;
    t = tgt;
    if ((c > t ? c - t : t - c) <= int'(rbfe_pkg::SnapLimit)) return tgt;
    v = (t > c) ? c + delta : c - delta;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic rbfe_pkg::out_item_t bulb_snapshot(int idx, bit ok, bit last);
    rbfe_pkg::out_item_t r;
    r.bulb_index = 3'(idx);
    r.cur_red    = ok ? cur_mdl[idx].red   : 8'd0;
    r.cur_green  = ok ? cur_mdl[idx].green : 8'd0;
    r.cur_blue   = ok ? cur_mdl[idx].blue  : 8'd0;
    r.tgt_red    = ok ? tgt_mdl[idx].red   : 8'd0;
    r.tgt_green  = ok ? tgt_mdl[idx].green : 8'd0;
    r.tgt_blue   = ok ? tgt_mdl[idx].blue  : 8'd0;
    r.last       = last;
    return r;
  endfunction

  // Update the shadow stores for one accepted beat and queue its results
  task automatic apply_op(rbfe_pkg::in_item_t it);
    int             n;
    int             f;
    int             delta;
    rbfe_pkg::rgb_t col;
    bit             ok;
    col = {it.red, it.green, it.blue};
    ok  = int'(it.bulb) < rbfe_pkg::MAX_BULBS;
    case (it.op)
      rbfe_pkg::OP_SET_TGT_ONE, rbfe_pkg::OP_SET_CUR_ONE: begin
        if (ok) begin
          if (it.op == rbfe_pkg::OP_SET_TGT_ONE) tgt_mdl[it.bulb] = col;
          else cur_mdl[it.bulb] = col;
        end
        pending_q.push_back(bulb_snapshot(int'(it.bulb), ok, 1'b1));
      end
      rbfe_pkg::OP_SET_TGT_ALL: begin
        foreach (tgt_mdl[i]) tgt_mdl[i] = col;
      end
      rbfe_pkg::OP_SET_CUR_ALL: begin
        foreach (cur_mdl[i]) cur_mdl[i] = col;
      end
      rbfe_pkg::OP_TICK: begin
        // count of 0 walks one bulb, 7 walks six
        n = int'(count_reg);
        if (n < 1) n = 1;
        if (n > 6) n = 6;
        if (n > rbfe_pkg::MAX_BULBS) n = rbfe_pkg::MAX_BULBS;
        for (int i = 0; i < n; i++) begin
          if (cur_mdl[i] != tgt_mdl[i]) begin
            f     = (2 * (i + 2)) / (3 * n);
            delta = int'(it.frame_time) * f;
            cur_mdl[i].red   = fade_channel(cur_mdl[i].red,   tgt_mdl[i].red,   delta);
            cur_mdl[i].green = fade_channel(cur_mdl[i].green, tgt_mdl[i].green, delta);
            cur_mdl[i].blue  = fade_channel(cur_mdl[i].blue,  tgt_mdl[i].blue,  delta);
          end
          pending_q.push_back(bulb_snapshot(i, 1'b1, i == n - 1));
        end
      end
      rbfe_pkg::OP_READ: begin
        pending_q.push_back(bulb_snapshot(int'(it.bulb), ok, 1'b1));
      end
      default: ;
    endcase
  endtask

  function automatic rbfe_pkg::in_item_t beat(logic [2:0] op, logic [2:0] bulb,
                                              logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b, logic [7:0] ft);
    rbfe_pkg::in_item_t it;
    it.op         = op;
    it.bulb       = bulb;
    it.red        = r;
    it.green      = g;
    it.blue       = b;
    it.frame_time = ft;
    return it;
  endfunction

  function automatic logic [7:0] near_value(logic [7:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 32)) - 16;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return 8'(x);
  endfunction

  function automatic rbfe_pkg::in_item_t random_beat();
    rbfe_pkg::in_item_t r;
    int                 pick;
    int                 mode;
    rbfe_pkg::rgb_t     base;
    pick   = $urandom_range(0, 99);
    r.bulb = 3'($urandom_range(0, 7));
    if (pick < 40) r.op = rbfe_pkg::OP_TICK;
    else if (pick < 55) r.op = rbfe_pkg::OP_SET_TGT_ONE;
    else if (pick < 68) r.op = rbfe_pkg::OP_SET_CUR_ONE;
    else if (pick < 74) r.op = rbfe_pkg::OP_SET_TGT_ALL;
    else if (pick < 80) r.op = rbfe_pkg::OP_SET_CUR_ALL;
    else if (pick < 94) r.op = rbfe_pkg::OP_READ;
    else r.op = $urandom_range(0, 1) ? OpUnusedA : OpUnusedB;
    // land colors near the opposite store often, so snaps and short moves occur
    base = (r.op == rbfe_pkg::OP_SET_TGT_ONE) ? cur_mdl[r.bulb] : tgt_mdl[r.bulb];
    mode = $urandom_range(0, 3);
    case (mode)
      0: begin
        r.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        r.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        r.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        r.red   = near_value(base.red);
        r.green = near_value(base.green);
        r.blue  = near_value(base.blue);
      end
      default: begin
        r.red   = 8'($urandom_range(0, 255));
        r.green = 8'($urandom_range(0, 255));
        r.blue  = 8'($urandom_range(0, 255));
      end
    endcase
    case ($urandom_range(0, 9))
      0:       r.frame_time = 8'd0;
      1:       r.frame_time = 8'hFF;
      2, 3:    r.frame_time = 8'($urandom_range(1, 8));
      default: r.frame_time = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  // Drive one beat, hold it until taken, then open a gap when the burst ends
  task automatic send_beat(rbfe_pkg::in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    apply_op(it);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid, drain all results, then let trailing no-result ops finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [rbfe_pkg::ApbAddrW-1:0] addr,
                           logic [rbfe_pkg::ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == rbfe_pkg::RegBulbCount) count_reg = data[rbfe_pkg::CntW-1:0];
    @(posedge clk_i);
  endtask

  task automatic cfg_check_count();
    logic [rbfe_pkg::ApbDataW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= rbfe_pkg::RegBulbCount;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rd = prdata;
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[rbfe_pkg::CntW-1:0] !== count_reg) begin
      note_failure($sformatf("bulb_count readback expected %0d, got %0d", count_reg,
                             rd[rbfe_pkg::CntW-1:0]));
    end
    @(posedge clk_i);
  endtask

  // Reset contents, overshoot to the channel limits, snap edge, ignored ops, all-writes
  task automatic test_reset_and_ops();
    for (int b = 0; b < rbfe_pkg::MAX_BULBS; b++) begin
      send_beat(beat(rbfe_pkg::OP_READ, 3'(b), 8'd0, 8'd0, 8'd0, 8'd0));
    end
    send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'hFF));
    send_beat(beat(rbfe_pkg::OP_TICK, 3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_beat(beat(rbfe_pkg::OP_SET_TGT_ONE, 3'd3, 8'hFF, 8'hFF, 8'hFF, 8'd0));
    send_beat(beat(rbfe_pkg::OP_SET_CUR_ONE, 3'd3, 8'd0, 8'd0, 8'd0, 8'hFF));
    send_beat(beat(rbfe_pkg::OP_READ, 3'd3, 8'hA5, 8'h5A, 8'hC3, 8'h3C));
    send_beat(beat(rbfe_pkg::OP_SET_TGT_ONE, 3'd0, 8'd10, 8'd0, 8'd5, 8'd0));
    // distance of exactly the snap limit: snap
    send_beat(beat(rbfe_pkg::OP_SET_CUR_ONE, 3'd0, 8'd22, 8'd12, 8'd0, 8'd0));
    send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd100));
    // one past the snap limit: step by frame time
    send_beat(beat(rbfe_pkg::OP_SET_CUR_ONE, 3'd0, 8'd23, 8'd13, 8'd18, 8'd0));
    send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd1));
    send_beat(beat(OpUnusedA, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_beat(beat(OpUnusedB, 3'd7, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(beat(rbfe_pkg::OP_READ, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_beat(beat(rbfe_pkg::OP_SET_CUR_ONE, 3'd0, 8'd200, 8'd0, 8'd100, 8'd0));
    send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_beat(beat(rbfe_pkg::OP_SET_CUR_ALL, 3'd0, 8'hFF, 8'h00, 8'hFF, 8'd0));
    send_beat(beat(rbfe_pkg::OP_SET_TGT_ALL, 3'd0, 8'h00, 8'hFF, 8'h00, 8'd0));
    send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd200));
    send_beat(beat(rbfe_pkg::OP_READ, 3'd5, 8'd0, 8'd0, 8'd0, 8'd0));
    settle();
  endtask

  // Walk the count through its extremes, out-of-range codes and an unmapped address
  task automatic test_bulb_count();
    logic [rbfe_pkg::CntW-1:0] setting [6];
    setting = '{3'd0, 3'd7, 3'd6, 3'd2, 3'd5, 3'd1};
    foreach (setting[k]) begin
      cfg_write(rbfe_pkg::RegBulbCount, rbfe_pkg::ApbDataW'(setting[k]));
      cfg_check_count();
      if (k == 0) begin
        cfg_write(RegBeyond, rbfe_pkg::ApbDataW'(3'd4));
        cfg_check_count();
      end
      send_beat(beat(rbfe_pkg::OP_SET_CUR_ALL, 3'd0, 8'($urandom_range(0, 255)), 8'h00,
                     8'hFF, 8'd0));
      send_beat(beat(rbfe_pkg::OP_SET_TGT_ALL, 3'd0, 8'($urandom_range(0, 255)), 8'hFF,
                     8'h00, 8'd0));
      send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'hFF));
      send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0,
                     8'($urandom_range(0, 255))));
      send_beat(beat(rbfe_pkg::OP_TICK, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_beat(beat(rbfe_pkg::OP_READ, 3'($urandom_range(0, 7)), 8'd0, 8'd0, 8'd0, 8'd0));
      settle();
    end
  endtask

  task automatic test_random_fades();
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(rbfe_pkg::RegBulbCount, rbfe_pkg::ApbDataW'($urandom_range(0, 7)));
      // one phase runs with no idling at all
      gap_max    = (ph == 1) ? 0 : $urandom_range(0, 6);
      max_stall  = (ph == 1) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 12);
      repeat (20) send_beat(random_beat());
      settle();
    end
  endtask

  // Output side stalls in runs of random length
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (max_stall > 0 && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, max_stall - 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    rbfe_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        note_failure({"unexpected result: ", show(out_data_o)});
      end else begin
        want = pending_q.pop_front();
        if (out_data_o !== want) begin
          note_failure($sformatf("expected %s, got %s", show(want), show(out_data_o)));
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    foreach (cur_mdl[i]) begin
      cur_mdl[i] = rbfe_pkg::CurReset;
      tgt_mdl[i] = rbfe_pkg::TgtReset;
    end
    count_reg = rbfe_pkg::CntW'(1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_and_ops();
    test_bulb_count();
    test_random_fades();
    settle();
    if (mismatch_cnt == 0 && pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
